// File: rtl/fwpmd_pkg.sv
package fwpmd_pkg;

  localparam int COUNT_W    = 16;
  localparam int DUTY_W     = 13;
  localparam int DRIVE_W    = 2;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ERR_W      = 19;
  localparam int INTEG_W    = 17;

  // speed = count * SPEED_SCALE / counts_per_rev
  localparam int SPEED_SCALE = 6000;
  localparam int SCALE_W     = 13;
  localparam int PROD_W      = COUNT_W + SCALE_W + 1;
  // |count * SPEED_SCALE| stays below 2**MAG_W
  localparam int MAG_W       = 28;
  localparam int RECIP_W     = MAG_W + 1;
  localparam int SPEED_W     = MAG_W + 1;
  localparam int DIFF_W      = SPEED_W + 1;

  localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
  localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};

  // pipeline: stage index of the register that feeds each stateful step
  localparam int STAGES   = 8;
  localparam int ST_INTEG = 4;
  localparam int ST_DUTY  = 7;

  localparam int MOTOR_COUNT_DEF    = 4;
  localparam int COUNTS_PER_REV_DEF = 1560;
  localparam int SWAPPED_MOTOR      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIMIT     = 3'd4;

  localparam logic [GAIN_W-1:0]  GAIN_P_RST         = 16'd6144;
  localparam logic [GAIN_W-1:0]  GAIN_I_RST         = 16'd768;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST         = 16'd0;
  localparam logic [LIMIT_W-1:0] INTEGRAL_LIMIT_RST = 16'd10000;
  localparam logic [DUTY_W-1:0]  DUTY_LIMIT_RST     = 13'd7000;

  typedef enum logic [DRIVE_W-1:0] {
    DRIVE_OFF = 2'd0,
    DRIVE_FWD = 2'd1,
    DRIVE_REV = 2'd2
  } drive_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [LIMIT_W-1:0] integral_limit;
    logic [DUTY_W-1:0]  duty_limit;
  } cfg_t;

  typedef struct packed {
    logic              adv;
    logic [STAGES-1:0] vld;
  } ctrl_t;

endpackage

// File: rtl/fwpmd_lane.sv
module fwpmd_lane
  import fwpmd_pkg::*;
#(
  parameter int COUNTS_PER_REV = COUNTS_PER_REV_DEF,
  parameter bit SWAPPED        = 1'b0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ctrl_t                     ctrl,
  input  cfg_t                      cfg,
  input  logic signed [COUNT_W-1:0] count,
  input  logic signed [COUNT_W-1:0] target,
  output logic [DUTY_W-1:0]         duty,
  output logic [DRIVE_W-1:0]        drive
);

  // reciprocal for the speed division, exact after one correction step
  localparam int DIV_SHIFT = MAG_W + $clog2(COUNTS_PER_REV);
  localparam logic [63:0] RECIP_FULL = (64'd1 << DIV_SHIFT) / COUNTS_PER_REV;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
  localparam logic [LIMIT_W-1:0] DIVISOR = LIMIT_W'(COUNTS_PER_REV);
  localparam int MQ_W   = MAG_W + RECIP_W;
  localparam int QD_W   = MAG_W + LIMIT_W;
  localparam int PP_W   = GAIN_W + 1 + ERR_W;
  localparam int PI_W   = GAIN_W + 1 + INTEG_W;
  localparam int PD_W   = GAIN_W + 1 + ERR_W + 1;
  localparam int ACC_W  = PD_W + 2;
  localparam int DQ_W   = ACC_W - 8;
  localparam int DSAT_W = DUTY_W + 1;

  localparam drive_t POS_DRIVE = SWAPPED ? DRIVE_REV : DRIVE_FWD;
  localparam drive_t NEG_DRIVE = SWAPPED ? DRIVE_FWD : DRIVE_REV;

  logic signed [PROD_W-1:0]  prod1_r;
  logic signed [COUNT_W-1:0] tgt1_r, tgt2_r, tgt3_r, tgt4_r;
  logic [MQ_W-1:0]           mq2_r;
  logic [MAG_W-1:0]          mag2_r, mag3_r;
  logic                      neg2_r, neg3_r;
  logic [MAG_W-1:0]          q0_3_r;
  logic [QD_W-1:0]           qd3_r;
  logic signed [SPEED_W-1:0] speed4_r;
  logic signed [ERR_W-1:0]   e5_r, e6_r;
  logic signed [ERR_W:0]     diff6_r;
  logic signed [INTEG_W-1:0] integ6_r;
  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic signed [ERR_W-1:0]   prev_r;
  logic signed [PP_W-1:0]    pp7_r;
  logic signed [PI_W-1:0]    pi7_r;
  logic signed [PD_W-1:0]    pd7_r;
  logic signed [DSAT_W-1:0]  duty8_r, duty8_nxt;
  logic [DUTY_W-1:0]         held_duty_r, held_duty_nxt;
  drive_t                    held_drive_r, held_drive_nxt;

  logic [MAG_W-1:0]          mag_c;
  logic [MQ_W-1:0]           mq_shift_c;
  logic [MAG_W-1:0]          q0_c;
  logic [MAG_W-1:0]          rem_c;
  logic [MAG_W-1:0]          q_c;
  logic signed [DIFF_W-1:0]  err_wide_c;
  logic signed [ERR_W-1:0]   err_c;

  always_comb begin
    logic signed [PROD_W-1:0] abs_v;
    abs_v = prod1_r[PROD_W-1] ? -prod1_r : prod1_r;
    mag_c = abs_v[MAG_W-1:0];
  end

  assign mq_shift_c = mq2_r >> DIV_SHIFT;
  assign q0_c       = mq_shift_c[MAG_W-1:0];

  // the reciprocal estimate is at most one below the true quotient
  assign rem_c = mag3_r - qd3_r[MAG_W-1:0];
  assign q_c   = q0_3_r + MAG_W'(rem_c >= MAG_W'(DIVISOR));

  always_comb begin
    err_wide_c = DIFF_W'(tgt4_r) - DIFF_W'(speed4_r);
    if (err_wide_c > DIFF_W'(ERR_MAX)) begin
      err_c = ERR_MAX;
    end else if (err_wide_c < DIFF_W'(ERR_MIN)) begin
      err_c = ERR_MIN;
    end else begin
      err_c = err_wide_c[ERR_W-1:0];
    end
  end

  always_comb begin
    logic signed [ERR_W:0] sum_v;
    logic signed [ERR_W:0] lim_v;
    sum_v = (ERR_W+1)'(integ_r) + (ERR_W+1)'(e5_r);
    lim_v = $signed({4'b0, cfg.integral_limit});
    if (sum_v > lim_v) begin
      integ_nxt = lim_v[INTEG_W-1:0];
    end else if (sum_v < -lim_v) begin
      integ_nxt = INTEG_W'(-lim_v);
    end else begin
      integ_nxt = sum_v[INTEG_W-1:0];
    end
  end

  always_comb begin
    logic signed [ACC_W-1:0] acc_v;
    logic signed [ACC_W-1:0] adj_v;
    logic signed [DQ_W-1:0]  q_v;
    logic signed [DQ_W-1:0]  dl_v;
    acc_v = ACC_W'(pp7_r) + ACC_W'(pi7_r) + ACC_W'(pd7_r);
    // truncate toward zero on the divide by 256
    adj_v = acc_v + (acc_v[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));
    q_v   = DQ_W'(adj_v >>> 8);
    dl_v  = $signed(DQ_W'(cfg.duty_limit));
    if (q_v > dl_v) begin
      duty8_nxt = dl_v[DSAT_W-1:0];
    end else if (q_v < -dl_v) begin
      duty8_nxt = DSAT_W'(-dl_v);
    end else begin
      duty8_nxt = q_v[DSAT_W-1:0];
    end
  end

  // zero duty keeps the last magnitude and pins
  always_comb begin
    logic signed [DSAT_W-1:0] neg_v;
    neg_v          = -duty8_r;
    held_duty_nxt  = held_duty_r;
    held_drive_nxt = held_drive_r;
    if (duty8_r > 0) begin
      held_duty_nxt  = duty8_r[DUTY_W-1:0];
      held_drive_nxt = POS_DRIVE;
    end else if (duty8_r < 0) begin
      held_duty_nxt  = neg_v[DUTY_W-1:0];
      held_drive_nxt = NEG_DRIVE;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      prod1_r  <= count * $signed({1'b0, SCALE_W'(SPEED_SCALE)});
      tgt1_r   <= target;
      mag2_r   <= mag_c;
      neg2_r   <= prod1_r[PROD_W-1];
      mq2_r    <= mag_c * RECIP;
      tgt2_r   <= tgt1_r;
      q0_3_r   <= q0_c;
      qd3_r    <= q0_c * DIVISOR;
      mag3_r   <= mag2_r;
      neg3_r   <= neg2_r;
      tgt3_r   <= tgt2_r;
      speed4_r <= neg3_r ? -$signed({1'b0, q_c}) : $signed({1'b0, q_c});
      tgt4_r   <= tgt3_r;
      e5_r     <= err_c;
      e6_r     <= e5_r;
      diff6_r  <= (ERR_W+1)'(e5_r) - (ERR_W+1)'(prev_r);
      integ6_r <= integ_nxt;
      pp7_r    <= $signed({1'b0, cfg.gain_p}) * e6_r;
      pi7_r    <= $signed({1'b0, cfg.gain_i}) * integ6_r;
      pd7_r    <= $signed({1'b0, cfg.gain_d}) * diff6_r;
      duty8_r  <= duty8_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r      <= '0;
      prev_r       <= '0;
      held_duty_r  <= '0;
      held_drive_r <= DRIVE_OFF;
    end else if (ctrl.adv) begin
      if (ctrl.vld[ST_INTEG]) begin
        integ_r <= integ_nxt;
        prev_r  <= e5_r;
      end
      if (ctrl.vld[ST_DUTY]) begin
        held_duty_r  <= held_duty_nxt;
        held_drive_r <= held_drive_nxt;
      end
    end
  end

  assign duty  = held_duty_nxt;
  assign drive = held_drive_nxt;

endmodule

// File: rtl/fwpmd_merge.sv
module fwpmd_merge
  import fwpmd_pkg::*;
#(
  parameter int MOTOR_COUNT = MOTOR_COUNT_DEF,
  parameter int OUT_W       = ((MOTOR_COUNT * (DUTY_W + DRIVE_W) + 7) / 8) * 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ctrl_t                                ctrl,
  input  logic [MOTOR_COUNT-1:0][DUTY_W-1:0]   lane_duty,
  input  logic [MOTOR_COUNT-1:0][DRIVE_W-1:0]  lane_drive,
  output logic                                 out_tvalid,
  output logic [OUT_W-1:0]                     out_tdata
);

  localparam int DRV_BASE = MOTOR_COUNT * DUTY_W;

  logic             out_tvalid_r;
  logic [OUT_W-1:0] out_tdata_r, out_tdata_nxt;

  // all duties first, then all pin codes
  always_comb begin
    out_tdata_nxt = '0;
    for (int m = 0; m < MOTOR_COUNT; m++) begin
      out_tdata_nxt[m*DUTY_W +: DUTY_W]              = lane_duty[m];
      out_tdata_nxt[DRV_BASE + m*DRIVE_W +: DRIVE_W] = lane_drive[m];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ctrl.adv) begin
      out_tvalid_r <= ctrl.vld[ST_DUTY];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// File: rtl/four_wheel_pid_motor_drive_core.sv
// Speed loop for four wheels: each input transaction is one control tick with an encoder
// count and a target speed per motor; each motor runs its own positional PID lane (speed
// scaling, clamped integral, Q8.8 gains, duty saturation) and one output transaction per
// tick carries each motor's duty magnitude and pin code, a zero duty holding the last ones.
// A new tick is accepted every clock cycle while the pipeline is not stalled; the lanes
// and the output register form a nine-stage pipeline, and the whole pipeline stalls only
// when the output register holds a result that has not been taken. The user must write
// gains and limits through the cfg port only while no tick is in flight; the block itself
// does not enforce this.
module four_wheel_pid_motor_drive_core
  import fwpmd_pkg::*;
#(
  parameter int MOTOR_COUNT    = MOTOR_COUNT_DEF,
  parameter int COUNTS_PER_REV = COUNTS_PER_REV_DEF,
  parameter int IN_W           = 2 * MOTOR_COUNT * COUNT_W,
  parameter int OUT_W          = ((MOTOR_COUNT * (DUTY_W + DRIVE_W) + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // count_one .. count_n, then target_one .. target_n, 16 bits each
  input  logic [IN_W-1:0]       in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // duty_one .. duty_n (13 bits each), then drive_one .. drive_n (2 bits each), zero pad
  output logic [OUT_W-1:0]      out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t              cfg_r;
  logic [STAGES-1:0] vld_r;
  ctrl_t             ctrl;

  logic [MOTOR_COUNT-1:0][DUTY_W-1:0]  lane_duty;
  logic [MOTOR_COUNT-1:0][DRIVE_W-1:0] lane_drive;

  assign ctrl.adv = !out_tvalid || out_tready;
  assign ctrl.vld = vld_r;
  assign in_tready = ctrl.adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctrl.adv) begin
      vld_r <= {vld_r[STAGES-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p         <= GAIN_P_RST;
      cfg_r.gain_i         <= GAIN_I_RST;
      cfg_r.gain_d         <= GAIN_D_RST;
      cfg_r.integral_limit <= INTEGRAL_LIMIT_RST;
      cfg_r.duty_limit     <= DUTY_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_GAIN_P:         cfg_r.gain_p         <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I:         cfg_r.gain_i         <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D:         cfg_r.gain_d         <= cfg_wdata[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT: cfg_r.integral_limit <= cfg_wdata[LIMIT_W-1:0];
        REG_DUTY_LIMIT:     cfg_r.duty_limit     <= cfg_wdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar m = 0; m < MOTOR_COUNT; m++) begin : g_lane
    fwpmd_lane #(
      .COUNTS_PER_REV (COUNTS_PER_REV),
      .SWAPPED        (m == SWAPPED_MOTOR)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (ctrl),
      .cfg    (cfg_r),
      .count  (in_tdata[m*COUNT_W +: COUNT_W]),
      .target (in_tdata[(MOTOR_COUNT + m)*COUNT_W +: COUNT_W]),
      .duty   (lane_duty[m]),
      .drive  (lane_drive[m])
    );
  end

  fwpmd_merge #(
    .MOTOR_COUNT (MOTOR_COUNT),
    .OUT_W       (OUT_W)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .lane_duty  (lane_duty),
    .lane_drive (lane_drive),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule
